/* rtl/two_opt_tour_improver_macros.svh */
// assertion macros for the tour improver
// used by the top level only
`ifndef TWO_OPT_TOUR_IMPROVER_MACROS_SVH
`define TWO_OPT_TOUR_IMPROVER_MACROS_SVH

// same-cycle implication
`define TOI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TOI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/toi_pkg.sv */
// shared types and constants for the tour improver
// no dependencies
`timescale 1ns / 1ps

package toi_pkg;

   localparam int CITY_BITS    = 5;
   localparam int IN_DIST_BITS = 16;
   localparam int COUNT_BITS   = 6;
   localparam int LIMIT_BITS   = 16;
   localparam int CSR_BITS     = 16;
   localparam int MIN_CITIES   = 4;
   localparam int EMIT_MAX     = 32;

   typedef enum logic [1:0] {
      KIND_LOAD_DIST = 2'd0,
      KIND_LOAD_TOUR = 2'd1,
      KIND_RUN       = 2'd2,
      KIND_NONE      = 2'd3
   } kind_type;

   typedef enum logic {
      CSR_CITY_COUNT = 1'b0,
      CSR_ITER_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_PASS, ST_RD_A, ST_RD_B, ST_CAP_B, ST_J_CHK, ST_RD_C, ST_RD_D,
      ST_CAP_D, ST_DIST_AB, ST_DIST_CD, ST_DIST_AC, ST_DIST_BD, ST_CAP_BD, ST_CMP,
      ST_REV_CHK, ST_REV_RD_LO, ST_REV_RD_HI, ST_REV_CAP, ST_REV_WR_LO,
      ST_REV_WR_HI, ST_EMIT_RD, ST_EMIT_OUT
   } state_type;

   typedef enum logic [2:0] {
      TS_I, TS_I1, TS_J, TS_J1, TS_LO, TS_HI, TS_K
   } tsel_type;

   typedef enum logic [2:0] {
      TC_NONE, TC_A, TC_B, TC_C, TC_D, TC_VLO, TC_VHI
   } tcap_type;

   typedef enum logic [1:0] {
      TW_NONE, TW_LOAD, TW_LO, TW_HI
   } twr_type;

   typedef enum logic [1:0] {
      DS_AB, DS_CD, DS_AC, DS_BD
   } dsel_type;

   typedef enum logic [2:0] {
      DC_NONE, DC_AB, DC_CD, DC_AC, DC_BD
   } dcap_type;

   typedef struct packed {
      logic     ld_dist;
      twr_type  twr;
      tsel_type tsel;
      tcap_type tcap;
      dsel_type dsel;
      dcap_type dcap;
      logic     run_init;
      logic     pass_start;
      logic     pass_inc;
      logic     i_inc;
      logic     j_inc;
      logic     rev_init;
      logic     rev_step;
      logic     emit;
   } cmd_type;

   typedef struct packed {
      logic n_lt_min;
      logic pass_done;
      logic j_ge_n;
      logic skip;
      logic i_more;
      logic improve;
      logic lo_lt_hi;
      logic k_done;
   } status_type;

endpackage

/* rtl/two_opt_tour_improver.sv */
// top level of the 2-opt tour improver: controller plus datapath
// depends on toi_pkg, toi_ctrl, toi_datapath and the assertion macro header
//
// usage: an item is taken when start is high and busy is low. kind selects
// a distance entry load (row, col, distance), a tour position load
// (position, city) or a run. loads finish in the cycle they are taken and
// busy stays low, so loads go at one per cycle when no run holds busy high.
// a run does first-improvement 2-opt passes and then emits the tour, one
// position per result on rsp_valid for a single cycle, rsp_last on the end.
// each pass opens with a start step, and each new i reads a and b from the
// tour memory. each candidate pair takes a check, the c and d tour reads,
// the four distance reads on the single read port of the distance memory
// and a compare; a skipped pair takes only the check. each reversal swap
// reads, captures and writes both ends, and a final check closes the
// reversal; emission reads each position and then outputs it. the number
// of pairs examined depends on the data, bounded by the pass limit times n*n.
// csr writes set city_count and iteration_limit and are taken at once.
// reset returns the controller to idle and the registers to 32 and 0;
// memories keep no reset value. results cannot be held off by the receiver.
`timescale 1ns / 1ps
`include "two_opt_tour_improver_macros.svh"

module two_opt_tour_improver #(
   parameter int MAX_CITIES = 32,
   parameter int DIST_BITS  = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_kind,
   input  logic [toi_pkg::CITY_BITS-1:0]     req_row,
   input  logic [toi_pkg::CITY_BITS-1:0]     req_col,
   input  logic [toi_pkg::IN_DIST_BITS-1:0]  req_distance,
   input  logic [toi_pkg::CITY_BITS-1:0]     req_position,
   input  logic [toi_pkg::CITY_BITS-1:0]     req_city,
   input  logic                              csr_write_en,
   input  logic                              csr_index,
   input  logic [toi_pkg::CSR_BITS-1:0]      csr_data,
   output logic                              rsp_valid,
   output logic [toi_pkg::CITY_BITS-1:0]     rsp_out_position,
   output logic [toi_pkg::CITY_BITS-1:0]     rsp_out_city,
   output logic                              rsp_last
);
   import toi_pkg::*;

   cmd_type    cmd;
   status_type status;

   toi_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .kind   (kind_type'(req_kind)),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   toi_datapath #(
      .MAX_CITIES (MAX_CITIES),
      .DIST_BITS  (DIST_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_row          (req_row),
      .req_col          (req_col),
      .req_distance     (req_distance),
      .req_position     (req_position),
      .req_city         (req_city),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_valid        (rsp_valid),
      .rsp_out_position (rsp_out_position),
      .rsp_out_city     (rsp_out_city),
      .rsp_last         (rsp_last)
   );

   `TOI_ASSERT_NOW(a_rsp_from_run, clock, reset, rsp_valid, $past(busy), "result outside a run")
   `TOI_ASSERT_NEXT(a_rsp_spacing, clock, reset, rsp_valid && !rsp_last, !rsp_valid, "results back to back")
   `TOI_ASSERT_NEXT(a_run_busy, clock, reset, start && !busy && (req_kind == KIND_RUN), busy, "run item not started")

endmodule

/* rtl/toi_ctrl.sv */
// sequencer for loads, 2-opt passes, reversals and tour emission
// depends on toi_pkg
`timescale 1ns / 1ps

module toi_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  toi_pkg::kind_type   kind,
   input  toi_pkg::status_type status,
   output toi_pkg::cmd_type    cmd,
   output logic                busy
);
   import toi_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.twr  = TW_NONE;
      cmd.tsel = TS_I;
      cmd.tcap = TC_NONE;
      cmd.dsel = DS_AB;
      cmd.dcap = DC_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (kind)
                  KIND_LOAD_DIST: cmd.ld_dist = 1'b1;
                  KIND_LOAD_TOUR: cmd.twr = TW_LOAD;
                  KIND_RUN: begin
                     cmd.run_init = 1'b1;
                     state_in = status.n_lt_min ? ST_EMIT_RD : ST_PASS;
                  end
                  default: ;
               endcase
            end
         end
         ST_PASS: begin
            if (status.pass_done) begin
               state_in = ST_EMIT_RD;
            end else begin
               cmd.pass_start = 1'b1;
               state_in = ST_RD_A;
            end
         end
         ST_RD_A: begin
            cmd.tsel = TS_I;
            state_in = ST_RD_B;
         end
         ST_RD_B: begin
            cmd.tcap = TC_A;
            cmd.tsel = TS_I1;
            state_in = ST_CAP_B;
         end
         ST_CAP_B: begin
            cmd.tcap = TC_B;
            state_in = ST_J_CHK;
         end
         ST_J_CHK: begin
            priority if (status.j_ge_n) begin
               if (status.i_more) begin
                  cmd.i_inc = 1'b1;
                  state_in = ST_RD_A;
               end else begin
                  state_in = ST_EMIT_RD;
               end
            end else if (status.skip) begin
               cmd.j_inc = 1'b1;
            end else begin
               state_in = ST_RD_C;
            end
         end
         ST_RD_C: begin
            cmd.tsel = TS_J;
            state_in = ST_RD_D;
         end
         ST_RD_D: begin
            cmd.tcap = TC_C;
            cmd.tsel = TS_J1;
            state_in = ST_CAP_D;
         end
         ST_CAP_D: begin
            cmd.tcap = TC_D;
            state_in = ST_DIST_AB;
         end
         ST_DIST_AB: begin
            cmd.dsel = DS_AB;
            state_in = ST_DIST_CD;
         end
         ST_DIST_CD: begin
            cmd.dcap = DC_AB;
            cmd.dsel = DS_CD;
            state_in = ST_DIST_AC;
         end
         ST_DIST_AC: begin
            cmd.dcap = DC_CD;
            cmd.dsel = DS_AC;
            state_in = ST_DIST_BD;
         end
         ST_DIST_BD: begin
            cmd.dcap = DC_AC;
            cmd.dsel = DS_BD;
            state_in = ST_CAP_BD;
         end
         ST_CAP_BD: begin
            cmd.dcap = DC_BD;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (status.improve) begin
               cmd.rev_init = 1'b1;
               state_in = ST_REV_CHK;
            end else begin
               cmd.j_inc = 1'b1;
               state_in = ST_J_CHK;
            end
         end
         ST_REV_CHK: begin
            if (status.lo_lt_hi) begin
               state_in = ST_REV_RD_LO;
            end else begin
               cmd.pass_inc = 1'b1;
               state_in = ST_PASS;
            end
         end
         ST_REV_RD_LO: begin
            cmd.tsel = TS_LO;
            state_in = ST_REV_RD_HI;
         end
         ST_REV_RD_HI: begin
            cmd.tcap = TC_VLO;
            cmd.tsel = TS_HI;
            state_in = ST_REV_CAP;
         end
         ST_REV_CAP: begin
            cmd.tcap = TC_VHI;
            state_in = ST_REV_WR_LO;
         end
         ST_REV_WR_LO: begin
            cmd.twr = TW_LO;
            state_in = ST_REV_WR_HI;
         end
         ST_REV_WR_HI: begin
            cmd.twr = TW_HI;
            cmd.rev_step = 1'b1;
            state_in = ST_REV_CHK;
         end
         ST_EMIT_RD: begin
            if (status.k_done) begin
               state_in = ST_IDLE;
            end else begin
               cmd.tsel = TS_K;
               state_in = ST_EMIT_OUT;
            end
         end
         ST_EMIT_OUT: begin
            cmd.emit = 1'b1;
            state_in = ST_EMIT_RD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

/* rtl/toi_datapath.sv */
// tour and distance memories, counters, cost compare and result register
// depends on toi_pkg
`timescale 1ns / 1ps

module toi_datapath #(
   parameter int MAX_CITIES = 32,
   parameter int DIST_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  toi_pkg::cmd_type                    cmd,
   output toi_pkg::status_type                 status,
   input  logic [toi_pkg::CITY_BITS-1:0]       req_row,
   input  logic [toi_pkg::CITY_BITS-1:0]       req_col,
   input  logic [toi_pkg::IN_DIST_BITS-1:0]    req_distance,
   input  logic [toi_pkg::CITY_BITS-1:0]       req_position,
   input  logic [toi_pkg::CITY_BITS-1:0]       req_city,
   input  logic                                csr_write_en,
   input  logic                                csr_index,
   input  logic [toi_pkg::CSR_BITS-1:0]        csr_data,
   output logic                                rsp_valid,
   output logic [toi_pkg::CITY_BITS-1:0]       rsp_out_position,
   output logic [toi_pkg::CITY_BITS-1:0]       rsp_out_city,
   output logic                                rsp_last
);
   import toi_pkg::*;

   localparam int TD   = (MAX_CITIES < EMIT_MAX) ? MAX_CITIES : EMIT_MAX;
   localparam int TIW  = $clog2(TD);
   localparam int CW   = $clog2(TD + 1);
   localparam int DD   = TD * TD;
   localparam int DAW  = $clog2(DD);
   localparam logic [DAW-1:0] TD_D = DAW'(TD);
   localparam logic [CW-1:0]  TD_C = CW'(TD);

   logic [COUNT_BITS-1:0] city_count_ff;
   logic [LIMIT_BITS-1:0] iter_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         city_count_ff <= COUNT_BITS'(EMIT_MAX);
         iter_limit_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_CITY_COUNT: city_count_ff <= csr_data[COUNT_BITS-1:0];
            CSR_ITER_LIMIT: iter_limit_ff <= csr_data[LIMIT_BITS-1:0];
            default: ;
         endcase
      end
   end

   logic [CW-1:0]         n;
   logic [2*CW-1:0]       n_sq;
   logic [LIMIT_BITS-1:0] limit;

   assign n     = (city_count_ff > COUNT_BITS'(TD)) ? TD_C : CW'(city_count_ff);
   assign n_sq  = (2*CW)'(n) * (2*CW)'(n);
   assign limit = (iter_limit_ff != '0) ? iter_limit_ff : LIMIT_BITS'(n_sq);

   logic [CITY_BITS-1:0] tmem [TD];
   logic [DIST_BITS-1:0] dmem [DD];

   logic [CW-1:0] i_ff, j_ff, lo_ff, hi_ff, k_ff;
   logic [LIMIT_BITS-1:0] pass_ff;
   logic [CITY_BITS-1:0] a_ff, b_ff, c_ff, d_ff, vlo_ff, vhi_ff, tq_ff;
   logic [DIST_BITS-1:0] dq_ff, dab_ff, dcd_ff, dac_ff, dbd_ff;
   logic dz_ff;

   logic [CW:0]   i_plus2;
   logic [CW-1:0] j_next;
   logic [CW-1:0] t_addr;
   logic [CW-1:0] w_addr_c;
   logic [CITY_BITS-1:0] w_data;
   logic          w_en;

   assign i_plus2 = (CW+1)'(i_ff) + (CW+1)'(2);
   assign j_next  = ((j_ff + CW'(1)) == n) ? '0 : (j_ff + CW'(1));

   always_comb begin
      unique case (cmd.tsel)
         TS_I:    t_addr = i_ff;
         TS_I1:   t_addr = i_ff + CW'(1);
         TS_J:    t_addr = j_ff;
         TS_J1:   t_addr = j_next;
         TS_LO:   t_addr = lo_ff;
         TS_HI:   t_addr = hi_ff;
         TS_K:    t_addr = k_ff;
         default: t_addr = k_ff;
      endcase
   end

   always_comb begin
      w_en     = 1'b0;
      w_addr_c = lo_ff;
      w_data   = vhi_ff;
      unique case (cmd.twr)
         TW_LOAD: begin
            w_en     = (int'(req_position) < TD);
            w_addr_c = CW'(req_position);
            w_data   = req_city;
         end
         TW_LO: begin
            w_en     = 1'b1;
            w_addr_c = lo_ff;
            w_data   = vhi_ff;
         end
         TW_HI: begin
            w_en     = 1'b1;
            w_addr_c = hi_ff;
            w_data   = vlo_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (w_en) begin
         tmem[w_addr_c[TIW-1:0]] <= w_data;
      end
      tq_ff <= tmem[t_addr[TIW-1:0]];
   end

   logic [CITY_BITS-1:0] d_from, d_to;
   logic [DAW-1:0]       d_raddr, d_waddr;
   logic                 d_zero;

   always_comb begin
      unique case (cmd.dsel)
         DS_AB:   begin d_from = a_ff; d_to = b_ff; end
         DS_CD:   begin d_from = c_ff; d_to = d_ff; end
         DS_AC:   begin d_from = a_ff; d_to = c_ff; end
         DS_BD:   begin d_from = b_ff; d_to = d_ff; end
         default: begin d_from = a_ff; d_to = b_ff; end
      endcase
   end

   assign d_zero  = (int'(d_from) >= TD) || (int'(d_to) >= TD);
   assign d_raddr = DAW'(DAW'(d_from[TIW-1:0]) * TD_D + DAW'(d_to[TIW-1:0]));
   assign d_waddr = DAW'(DAW'(req_row[TIW-1:0]) * TD_D + DAW'(req_col[TIW-1:0]));

   always_ff @(posedge clock) begin
      if (cmd.ld_dist && (int'(req_row) < TD) && (int'(req_col) < TD)) begin
         dmem[d_waddr] <= DIST_BITS'(req_distance);
      end
      dq_ff <= dmem[d_raddr];
      dz_ff <= d_zero;
   end

   logic [DIST_BITS-1:0] dval;
   logic [DIST_BITS:0]   cost_now, cost_alt;

   assign dval     = dz_ff ? '0 : dq_ff;
   assign cost_now = (DIST_BITS+1)'(dab_ff) + (DIST_BITS+1)'(dcd_ff);
   assign cost_alt = (DIST_BITS+1)'(dac_ff) + (DIST_BITS+1)'(dbd_ff);

   always_ff @(posedge clock) begin
      unique case (cmd.tcap)
         TC_A:    a_ff   <= tq_ff;
         TC_B:    b_ff   <= tq_ff;
         TC_C:    c_ff   <= tq_ff;
         TC_D:    d_ff   <= tq_ff;
         TC_VLO:  vlo_ff <= tq_ff;
         TC_VHI:  vhi_ff <= tq_ff;
         default: ;
      endcase
      unique case (cmd.dcap)
         DC_AB:   dab_ff <= dval;
         DC_CD:   dcd_ff <= dval;
         DC_AC:   dac_ff <= dval;
         DC_BD:   dbd_ff <= dval;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff    <= '0;
         j_ff    <= '0;
         lo_ff   <= '0;
         hi_ff   <= '0;
         k_ff    <= '0;
         pass_ff <= '0;
      end else begin
         if (cmd.run_init) begin
            pass_ff <= '0;
            k_ff    <= '0;
         end
         if (cmd.pass_start) begin
            i_ff <= '0;
            j_ff <= CW'(2);
         end
         if (cmd.pass_inc) begin
            pass_ff <= pass_ff + LIMIT_BITS'(1);
         end
         if (cmd.i_inc) begin
            i_ff <= i_ff + CW'(1);
            j_ff <= i_ff + CW'(3);
         end
         if (cmd.j_inc) begin
            j_ff <= j_ff + CW'(1);
         end
         if (cmd.rev_init) begin
            lo_ff <= i_ff + CW'(1);
            hi_ff <= j_ff;
         end
         if (cmd.rev_step) begin
            lo_ff <= lo_ff + CW'(1);
            hi_ff <= hi_ff - CW'(1);
         end
         if (cmd.emit) begin
            k_ff <= k_ff + CW'(1);
         end
      end
   end

   logic rsp_valid_ff;
   logic [CITY_BITS-1:0] rsp_pos_ff, rsp_city_ff;
   logic rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
      if (cmd.emit) begin
         rsp_pos_ff  <= CITY_BITS'(k_ff);
         rsp_city_ff <= tq_ff;
         rsp_last_ff <= ((k_ff + CW'(1)) == n);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_position = rsp_pos_ff;
   assign rsp_out_city     = rsp_city_ff;
   assign rsp_last         = rsp_last_ff;

   assign status.n_lt_min  = (int'(n) < MIN_CITIES);
   assign status.pass_done = (pass_ff == limit);
   assign status.j_ge_n    = (j_ff >= n);
   assign status.skip      = (i_ff == '0) && ((j_ff + CW'(1)) == n);
   assign status.i_more    = (i_plus2 < (CW+1)'(n));
   assign status.improve   = (cost_alt < cost_now);
   assign status.lo_lt_hi  = (lo_ff < hi_ff);
   assign status.k_done    = (k_ff == n);

endmodule

/* bench/tb_top.sv */
// self-checking bench for the 2-opt tour improver: directed table, then random items
// depends on toi_pkg and two_opt_tour_improver
`timescale 1ns / 1ps

module tb_top;
   import toi_pkg::*;

   typedef struct packed {
      kind_type    kind;
      logic [4:0]  row;
      logic [4:0]  col;
      logic [15:0] distance;
      logic [4:0]  position;
      logic [4:0]  city;
   } req_item_t;

   typedef struct packed {
      logic [4:0] position;
      logic [4:0] city;
      logic       last;
   } tour_entry_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_kind = KIND_NONE;
   logic [4:0] req_row = '0, req_col = '0, req_position = '0, req_city = '0;
   logic [15:0] req_distance = '0;
   logic csr_write_en = 1'b0;
   logic csr_index = CSR_CITY_COUNT;
   logic [15:0] csr_data = '0;
   logic rsp_valid, rsp_last;
   logic [4:0] rsp_out_position, rsp_out_city;

   two_opt_tour_improver DUT (.*);

   logic [15:0] dist_mem [0:1023];
   logic [4:0]  tour_mem [0:31];
   logic [5:0]  cities_cfg;
   logic [15:0] pass_cap;
   tour_entry_t emitted_tours [$];
   int errors = 0;
   int send_idle = 0;
   int n_dirs = 0;
   req_item_t dirs [0:31];

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #100ms;
      $display("FAIL two_opt_tour_improver");
      $finish;
   end

   function automatic logic [16:0] dist_of(input logic [4:0] f, input logic [4:0] t);
      return {1'b0, dist_mem[{f, t}]};
   endfunction

   function automatic bit try_improve(input int n);
      int i, j, lo, hi;
      logic [4:0] a, b, c, d, tmp;
      logic [16:0] now_len, alt_len;
      for (i = 0; i + 1 < n; i++) begin
         a = tour_mem[i];
         b = tour_mem[i+1];
         for (j = i + 2; j < n; j++) begin
            if (i == 0 && j == n - 1) continue;
            c = tour_mem[j];
            d = tour_mem[(j + 1 == n) ? 0 : j + 1];
            now_len = dist_of(a, b) + dist_of(c, d);
            alt_len = dist_of(a, c) + dist_of(b, d);
            if (alt_len < now_len) begin
               lo = i + 1;
               hi = j;
               while (lo < hi) begin
                  tmp = tour_mem[lo];
                  tour_mem[lo] = tour_mem[hi];
                  tour_mem[hi] = tmp;
                  lo++;
                  hi--;
               end
               return 1'b1;
            end
         end
      end
      return 1'b0;
   endfunction

   task automatic predict_item(input req_item_t it);
      int n, k, lim, p;
      case (it.kind)
         KIND_LOAD_DIST: dist_mem[{it.row, it.col}] = it.distance;
         KIND_LOAD_TOUR: tour_mem[it.position] = it.city;
         KIND_RUN: begin
            n = (cities_cfg > 32) ? 32 : cities_cfg;
            if (n >= MIN_CITIES) begin
               lim = (pass_cap != 0) ? pass_cap : n * n;
               p = 0;
               while (p < lim) begin
                  p++;
                  if (!try_improve(n)) break;
               end
            end
            for (k = 0; k < n; k++)
               emitted_tours.push_back('{k[4:0], tour_mem[k], k == n - 1});
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      tour_entry_t e;
      if (!reset && rsp_valid) begin
         if (emitted_tours.size() == 0) begin
            $display("%0t unexpected result pos %0d city %0d", $time, rsp_out_position,
               rsp_out_city);
            errors++;
         end else begin
            e = emitted_tours.pop_front();
            if (e.position !== rsp_out_position) begin
               $display("%0t position exp %0d got %0d", $time, e.position, rsp_out_position);
               errors++;
            end
            if (e.city !== rsp_out_city) begin
               $display("%0t city exp %0d got %0d", $time, e.city, rsp_out_city);
               errors++;
            end
            if (e.last !== rsp_last) begin
               $display("%0t last exp %0d got %0d", $time, e.last, rsp_last);
               errors++;
            end
         end
      end
   end

   task automatic send_item(input req_item_t it);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_kind <= it.kind;
      req_row <= it.row;
      req_col <= it.col;
      req_distance <= it.distance;
      req_position <= it.position;
      req_city <= it.city;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_item(it);
   endtask

   task automatic drain;
      int guard;
      guard = 0;
      start <= 1'b0;
      while ((emitted_tours.size() != 0 || busy) && guard < 2000000) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [15:0] val);
      drain();
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_CITY_COUNT) cities_cfg = val[5:0];
      else pass_cap = val;
   endtask

   function automatic req_item_t mk(input kind_type k, input int r, input int c,
      input int dv, input int p, input int ct);
      return '{k, r[4:0], c[4:0], dv[15:0], p[4:0], ct[4:0]};
   endfunction

   task automatic load_all(input int n, input int maxd);
      int r, c;
      for (r = 0; r < n; r++)
         for (c = 0; c < n; c++)
            send_item(mk(KIND_LOAD_DIST, r, c, $urandom_range(maxd), $urandom, $urandom));
   endtask

   // cities are drawn from 0..span-1 so every distance read was loaded
   task automatic load_tour(input int n, input int span);
      int k, t, s;
      int perm [0:31];
      for (k = 0; k < n; k++) perm[k] = k;
      for (k = n - 1; k > 0; k--) begin
         s = $urandom_range(k);
         t = perm[k];
         perm[k] = perm[s];
         perm[s] = t;
      end
      for (k = 0; k < n; k++)
         send_item(mk(KIND_LOAD_TOUR, $urandom, $urandom, $urandom, k,
            (span < n || $urandom_range(9) == 0) ? $urandom_range(span - 1) : perm[k]));
   endtask

   initial begin
      int ph, k, n, sent;
      int sizes [0:3];
      sizes = '{4, 5, 6, 7};
      cities_cfg = 6'd32;
      pass_cap = 16'd0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: four cities, all zero distances except a crossing
      write_csr(CSR_CITY_COUNT, 16'd4);
      for (k = 0; k < 16; k++) begin
         send_item(mk(KIND_LOAD_DIST, k / 4, k % 4, (k == 1 || k == 14) ? 16'hffff : 0, 31, 31));
      end
      for (k = 0; k < 4; k++) send_item(mk(KIND_LOAD_TOUR, 0, 31, 0, k, k));
      n_dirs = 0;
      dirs[n_dirs] = mk(KIND_LOAD_DIST, 31, 31, 16'hffff, 0, 0);
      n_dirs++;
      dirs[n_dirs] = mk(KIND_NONE, 31, 31, 16'hffff, 31, 31);
      n_dirs++;
      dirs[n_dirs] = mk(KIND_RUN, 0, 0, 0, 0, 0);
      n_dirs++;
      for (k = 0; k < n_dirs; k++) send_item(dirs[k]);
      drain();
      write_csr(CSR_CITY_COUNT, 16'd3);
      send_item(mk(KIND_RUN, 0, 0, 0, 0, 0));
      write_csr(CSR_CITY_COUNT, 16'd0);
      send_item(mk(KIND_RUN, 0, 0, 0, 0, 0));
      write_csr(CSR_ITER_LIMIT, 16'd1);
      write_csr(CSR_CITY_COUNT, 16'd4);
      send_item(mk(KIND_RUN, 0, 0, 0, 0, 0));
      write_csr(CSR_ITER_LIMIT, 16'hffff);

      // random: small tours, several idle phases
      sent = 0;
      for (ph = 0; ph < 4; ph++) begin
         send_idle = (ph == 0) ? 0 : (ph == 3) ? 24 : 71;
         n = sizes[$urandom_range(3)];
         write_csr(CSR_ITER_LIMIT, 16'(($urandom_range(2) == 0) ? $urandom_range(3) : 0));
         write_csr(CSR_CITY_COUNT, 16'(n));
         load_all(n, ($urandom_range(1) == 0) ? 65535 : 15);
         load_tour(n, n);
         send_item(mk(KIND_RUN, $urandom, $urandom, $urandom, $urandom, $urandom));
         send_item(mk(KIND_RUN, $urandom, $urandom, $urandom, $urandom, $urandom));
      end

      // full size twice, a 32-position tour over the four loaded cities
      send_idle = 0;
      write_csr(CSR_ITER_LIMIT, 16'd2);
      write_csr(CSR_CITY_COUNT, 16'd63);
      load_tour(32, 4);
      send_item(mk(KIND_RUN, 0, 0, 0, 0, 0));
      write_csr(CSR_CITY_COUNT, 16'd32);
      send_item(mk(KIND_RUN, 0, 0, 0, 0, 0));
      drain();

      if (errors == 0 && emitted_tours.size() == 0) begin
         $display("PASS two_opt_tour_improver");
      end else begin
         $display("FAIL two_opt_tour_improver");
      end
      $finish;
   end

endmodule
